/* hdl/rlt_pkg.sv */
// ----------------------------------------------------------------------------
// Redo-log transaction tracker package
// Shared sizes, request and status codes, and the chain control word.
// ----------------------------------------------------------------------------
package rlt_pkg;

  // Table geometry.
  localparam int LOG_ENTRIES = 30;
  localparam int BLK_W       = 24;
  localparam int STEP_W      = $clog2(LOG_ENTRIES);
  localparam int CNT_W       = 5;

  // Request codes.
  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_END   = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Result status codes.
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_WAIT     = 4'd1;
  localparam logic [3:0] ST_TOO_BIG  = 4'd2;
  localparam logic [3:0] ST_OUTSIDE  = 4'd3;
  localparam logic [3:0] ST_UNMATCH  = 4'd4;
  localparam logic [3:0] ST_LOG_COPY = 4'd5;
  localparam logic [3:0] ST_HEADER   = 4'd6;
  localparam logic [3:0] ST_INSTALL  = 4'd7;
  localparam logic [3:0] ST_DISABLED = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOG_START   = 2'd0;
  localparam logic [1:0] CFG_LOG_SIZE    = 2'd1;
  localparam logic [1:0] CFG_OP_RESERVE  = 2'd2;
  localparam logic [1:0] CFG_LOG_ENABLED = 2'd3;

  // Control word for the ring of table cells.
  typedef struct packed {
    logic shift;    // rotate the ring by one cell
    logic replace;  // the word entering the tail is the new block
  } chain_ctrl_t;

endpackage

/* hdl/redo_log_transaction_tracker.sv */
// A word that gives one result has it registered from the decide state once
// the output register is free. A write request first rotates the table ring
// once. A commit rotates the ring twice, one cell a cycle while the output
// register is free, and gives its 2n+2 results. One request is in work at a
// time: the next word is taken the cycle after the last result is loaded. Reset
// (rst, synchronous) clears counts and state and sets the config defaults.
// ----------------------------------------------------------------------------
// Redo-log transaction tracker
// Grants operations against log space, records written blocks with
// absorption of repeats, and plays out the group-commit sequence.
// ----------------------------------------------------------------------------
module redo_log_transaction_tracker
  import rlt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [23:0]      cfg_data,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [1:0]       req_type,
  input  logic [23:0]      block_number,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic [3:0]       status,
  output logic [23:0]      src_block,
  output logic [23:0]      dst_block,
  output logic [4:0]       header_count,
  output logic [4:0]       slot,
  output logic             last
);

  // Controller state codes.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_SEARCH  = 3'd2;
  localparam logic [2:0] S_WRESP   = 3'd3;
  localparam logic [2:0] S_COPY    = 3'd4;
  localparam logic [2:0] S_HDR     = 3'd5;
  localparam logic [2:0] S_INSTALL = 3'd6;
  localparam logic [2:0] S_CLR     = 3'd7;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LOG_ENTRIES - 1);

  // Configuration registers.
  logic [23:0] log_start;
  logic [10:0] log_size;
  logic [4:0]  op_reserve;
  logic        log_enabled;

  // Control state.
  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  entry_count_next;
  logic [CNT_W-1:0]  open_ops;
  logic [CNT_W-1:0]  open_ops_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              found;
  logic              found_next;
  logic [STEP_W-1:0] found_idx;
  logic [STEP_W-1:0] found_idx_next;

  // Held request word.
  logic [1:0]       hold_type;
  logic [BLK_W-1:0] hold_blk;

  // Ring interface.
  chain_ctrl_t      chain_ctrl;
  logic [BLK_W-1:0] head;

  // Result emitted this cycle.
  logic              emit;
  logic [3:0]        e_status;
  logic [23:0]       e_src;
  logic [23:0]       e_dst;
  logic [4:0]        e_cnt;
  logic [4:0]        e_slot;
  logic              e_last;

  logic              out_free;
  logic [5:0]        ops_inc;
  logic [10:0]       need;
  logic [23:0]       log_addr;
  logic              in_table;
  logic              hit;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // Space check for a begin request.
  assign ops_inc  = {1'b0, open_ops} + 6'd1;
  assign need     = 11'({5'b0, ops_inc} * {6'b0, op_reserve}) + {6'b0, entry_count};

  // Log slot address for the current ring position, and search match.
  assign log_addr = log_start + 24'(step) + 24'd1;
  assign in_table = (CNT_W'(step) < entry_count);
  assign hit      = in_table && (head == hold_blk) && !found;

  rlt_chain u_chain (
    .clk   (clk),
    .ctrl  (chain_ctrl),
    .wdata (hold_blk),
    .head  (head)
  );

  // Sequencer: decides the next state, ring moves and the result to emit.
  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    open_ops_next    = open_ops;
    step_next        = step;
    found_next       = found;
    found_idx_next   = found_idx;
    chain_ctrl       = '0;
    emit             = 1'b0;
    e_status         = ST_OK;
    e_src            = '0;
    e_dst            = '0;
    e_cnt            = '0;
    e_slot           = '0;
    e_last           = 1'b1;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (!log_enabled) begin
            e_status = ST_DISABLED;
          end else begin
            case (hold_type)
              REQ_BEGIN: begin
                if (open_ops == '1 || need > 11'(LOG_ENTRIES)) begin
                  e_status = ST_WAIT;
                end else begin
                  open_ops_next = open_ops + CNT_W'(1);
                end
              end
              REQ_WRITE: begin
                if (entry_count >= CNT_W'(LOG_ENTRIES) ||
                    {6'b0, entry_count} + 11'd1 >= log_size) begin
                  e_status = ST_TOO_BIG;
                end else if (open_ops == '0) begin
                  e_status = ST_OUTSIDE;
                end else begin
                  emit           = 1'b0;
                  state_next     = S_SEARCH;
                  step_next      = '0;
                  found_next     = 1'b0;
                  found_idx_next = '0;
                end
              end
              REQ_END: begin
                if (open_ops == '0) begin
                  e_status = ST_UNMATCH;
                end else begin
                  open_ops_next = open_ops - CNT_W'(1);
                  if (open_ops == CNT_W'(1) && entry_count != '0) begin
                    emit       = 1'b0;
                    state_next = S_COPY;
                    step_next  = '0;
                  end
                end
              end
              default: begin
                e_status = ST_OK;
              end
            endcase
          end
        end
      end

      // One full turn of the ring; a new block goes in at the first free slot.
      S_SEARCH: begin
        chain_ctrl.shift   = 1'b1;
        chain_ctrl.replace = (CNT_W'(step) == entry_count) && !found;
        if (hit) begin
          found_next     = 1'b1;
          found_idx_next = step;
        end
        if (step == LAST_STEP) begin
          state_next = S_WRESP;
          step_next  = '0;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end

      S_WRESP: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (found) begin
            e_slot = 5'(found_idx);
          end else begin
            e_slot           = entry_count;
            entry_count_next = entry_count + CNT_W'(1);
          end
        end
      end

      // Copy each entry into the log, one ring step at a time.
      S_COPY: begin
        if (out_free) begin
          chain_ctrl.shift = 1'b1;
          emit             = in_table;
          e_status         = ST_LOG_COPY;
          e_src            = head;
          e_dst            = log_addr;
          e_slot           = 5'(step);
          e_last           = 1'b0;
          if (step == LAST_STEP) begin
            state_next = S_HDR;
            step_next  = '0;
          end else begin
            step_next = step + STEP_W'(1);
          end
        end
      end

      S_HDR: begin
        if (out_free) begin
          emit       = 1'b1;
          e_status   = ST_HEADER;
          e_dst      = log_start;
          e_cnt      = entry_count;
          e_last     = 1'b0;
          state_next = S_INSTALL;
        end
      end

      // Install each logged block at its home address.
      S_INSTALL: begin
        if (out_free) begin
          chain_ctrl.shift = 1'b1;
          emit             = in_table;
          e_status         = ST_INSTALL;
          e_src            = log_addr;
          e_dst            = head;
          e_slot           = 5'(step);
          e_last           = 1'b0;
          if (step == LAST_STEP) begin
            state_next = S_CLR;
            step_next  = '0;
          end else begin
            step_next = step + STEP_W'(1);
          end
        end
      end

      S_CLR: begin
        if (out_free) begin
          emit             = 1'b1;
          e_status         = ST_HEADER;
          e_dst            = log_start;
          entry_count_next = '0;
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      open_ops    <= '0;
      step        <= '0;
      found       <= 1'b0;
      found_idx   <= '0;
      rsp_valid   <= 1'b0;
      log_start   <= 24'd0;
      log_size    <= 11'd31;
      op_reserve  <= 5'd10;
      log_enabled <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      open_ops    <= open_ops_next;
      step        <= step_next;
      found       <= found_next;
      found_idx   <= found_idx_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOG_START:   log_start   <= cfg_data;
          CFG_LOG_SIZE:    log_size    <= cfg_data[10:0];
          CFG_OP_RESERVE:  op_reserve  <= cfg_data[4:0];
          CFG_LOG_ENABLED: log_enabled <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: request hold and result word.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold_type <= req_type;
      hold_blk  <= block_number;
    end
    if (emit) begin
      status       <= e_status;
      src_block    <= e_src;
      dst_block    <= e_dst;
      header_count <= e_cnt;
      slot         <= e_slot;
      last         <= e_last;
    end
  end

`ifndef SYNTHESIS
  // The table never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(LOG_ENTRIES))
    else $error("entry count beyond table size");

  // The header clear empties the table and ends the commit.
  a_commit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR && out_free) |=> (entry_count == '0 && state == S_IDLE))
    else $error("commit did not clear the table");

  // A new result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwritten while waiting");

  // Ring position is at rest whenever the sequencer is idle.
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (step == '0))
    else $error("ring step left non-zero");
`endif

endmodule

/* hdl/rlt_cell.sv */
// ----------------------------------------------------------------------------
// Table cell
// Holds one table entry and takes its neighbour's word when the ring shifts.
// ----------------------------------------------------------------------------
module rlt_cell
  import rlt_pkg::*;
(
  input  logic             clk,
  input  logic             shift,
  input  logic [BLK_W-1:0] d_in,
  output logic [BLK_W-1:0] q
);

  // Entry register; contents are undefined until written, so no reset.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d_in;
    end
  end

endmodule

/* hdl/rlt_chain.sv */
// ----------------------------------------------------------------------------
// Table ring
// A row of cells closed into a ring. Cell 0 is the head that the control
// logic reads; the head word, or a new block, re-enters at the tail.
// ----------------------------------------------------------------------------
module rlt_chain
  import rlt_pkg::*;
(
  input  logic             clk,
  input  chain_ctrl_t      ctrl,
  input  logic [BLK_W-1:0] wdata,
  output logic [BLK_W-1:0] head
);

  logic [BLK_W-1:0] cell_q [LOG_ENTRIES];
  logic [BLK_W-1:0] cell_d [LOG_ENTRIES];

  // Each cell takes its upper neighbour; the tail takes the head or the new word.
  always_comb begin
    for (int k = 0; k < LOG_ENTRIES - 1; k++) begin
      cell_d[k] = cell_q[k+1];
    end
    cell_d[LOG_ENTRIES-1] = ctrl.replace ? wdata : cell_q[0];
  end

  for (genvar g = 0; g < LOG_ENTRIES; g++) begin : g_cell
    rlt_cell u_cell (
      .clk   (clk),
      .shift (ctrl.shift),
      .d_in  (cell_d[g]),
      .q     (cell_q[g])
    );
  end

  assign head = cell_q[0];

endmodule

/* tb/sv/tb_redo_log_transaction_tracker.sv */
// ----------------------------------------------------------------------------
// Redo-log transaction tracker testbench
// Sends begin, write and end requests under several register settings and
// idling patterns, works out every result word from a private copy of the
// tracker state, and checks each returned word in order against it.
// ----------------------------------------------------------------------------
module tb_redo_log_transaction_tracker;
  import rlt_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int OPEN_MAX    = (1 << CNT_W) - 1;
  localparam int TAIL_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int HOT_COUNT   = 6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] blk;
  } log_request_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [23:0] src;
    logic [23:0] dst;
    logic [4:0]  hdr;
    logic [4:0]  slot;
    logic        last;
  } log_result_t;

  // Block ports, all inputs known from time zero.
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_we       = 1'b0;
  logic [1:0]  cfg_index    = 2'd0;
  logic [23:0] cfg_data     = 24'd0;
  logic        req_valid    = 1'b0;
  logic        req_ready;
  logic [1:0]  req_type     = 2'd0;
  logic [23:0] block_number = 24'd0;
  logic        rsp_valid;
  logic        rsp_ready    = 1'b0;
  logic [3:0]  status;
  logic [23:0] src_block;
  logic [23:0] dst_block;
  logic [4:0]  header_count;
  logic [4:0]  slot;
  logic        last;

  // Stimulus and result stores.
  log_request_t pending_reqs[$];
  log_result_t  log_results_due[$];
  log_request_t next_req;
  log_result_t  seen_word;
  log_result_t  due_word;
  logic [23:0]  hot_blocks[HOT_COUNT];
  bit           holding        = 1'b0;
  bit           req_taken      = 1'b0;
  bit           hold_request   = 1'b0;
  int           hold_left      = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           mismatch_count = 0;

  // Private copy of the registers and the tracker state.
  logic [23:0]  c_start   = 24'd0;
  logic [10:0]  c_size    = 11'd31;
  logic [4:0]   c_reserve = 5'd10;
  logic         c_enabled = 1'b0;
  int           m_entries = 0;
  int           m_open    = 0;
  logic [23:0]  m_table[LOG_ENTRIES];

  redo_log_transaction_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_type     (req_type),
    .block_number (block_number),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .src_block    (src_block),
    .dst_block    (dst_block),
    .header_count (header_count),
    .slot         (slot),
    .last         (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Adds one result word to the back of the list of words still due.
  task automatic push_result(input logic [3:0] st, input logic [23:0] src,
                             input logic [23:0] dst, input logic [4:0] hdr,
                             input logic [4:0] slt, input logic lst);
    log_results_due.push_back({st, src, dst, hdr, slt, lst});
  endtask

  // Works out the words that one accepted request gives and updates the
  // private tracker state accordingly.
  task automatic play_request(input logic [1:0] kind, input logic [23:0] blk);
    int need;
    int idx;
    int n;
    int i;
    if (!c_enabled) begin
      push_result(ST_DISABLED, 24'd0, 24'd0, 5'd0, 5'd0, 1'b1);
    end else begin
      case (kind)
        REQ_BEGIN: begin
          need = m_entries + (m_open + 1) * int'(c_reserve);
          if (m_open >= OPEN_MAX || need > LOG_ENTRIES) begin
            push_result(ST_WAIT, 24'd0, 24'd0, 5'd0, 5'd0, 1'b1);
          end else begin
            m_open++;
            push_result(ST_OK, 24'd0, 24'd0, 5'd0, 5'd0, 1'b1);
          end
        end
        REQ_WRITE: begin
          // Size checks take precedence over the open-transaction check.
          if (m_entries >= LOG_ENTRIES || m_entries + 1 >= int'(c_size)) begin
            push_result(ST_TOO_BIG, 24'd0, 24'd0, 5'd0, 5'd0, 1'b1);
          end else if (m_open == 0) begin
            push_result(ST_OUTSIDE, 24'd0, 24'd0, 5'd0, 5'd0, 1'b1);
          end else begin
            // A block already held is absorbed into its existing slot.
            idx = 0;
            while (idx < m_entries && m_table[idx] != blk) idx++;
            m_table[idx] = blk;
            if (idx == m_entries) m_entries++;
            push_result(ST_OK, 24'd0, 24'd0, 5'd0, 5'(idx), 1'b1);
          end
        end
        REQ_END: begin
          if (m_open == 0) begin
            push_result(ST_UNMATCH, 24'd0, 24'd0, 5'd0, 5'd0, 1'b1);
          end else begin
            m_open--;
            if (m_open != 0 || m_entries == 0) begin
              push_result(ST_OK, 24'd0, 24'd0, 5'd0, 5'd0, 1'b1);
            end else begin
              // Group commit: log copies, header, home installs, header clear.
              n = m_entries;
              for (i = 0; i < n; i++) begin
                push_result(ST_LOG_COPY, m_table[i], c_start + 24'(i + 1), 5'd0,
                            5'(i), 1'b0);
              end
              push_result(ST_HEADER, 24'd0, c_start, 5'(n), 5'd0, 1'b0);
              for (i = 0; i < n; i++) begin
                push_result(ST_INSTALL, c_start + 24'(i + 1), m_table[i], 5'd0,
                            5'(i), 1'b0);
              end
              push_result(ST_HEADER, 24'd0, c_start, 5'd0, 5'd0, 1'b1);
              m_entries = 0;
            end
          end
        end
        default: begin
          push_result(ST_OK, 24'd0, 24'd0, 5'd0, 5'd0, 1'b1);
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input bit orphan, input log_result_t want,
                                 input log_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (orphan) begin
        $display("%0t: result word with nothing due: st=%0d src=%h dst=%h hdr=%0d slot=%0d last=%b",
                 $time, got.status, got.src, got.dst, got.hdr, got.slot, got.last);
      end else begin
        $display("%0t: expected st=%0d src=%h dst=%h hdr=%0d slot=%0d last=%b",
                 $time, want.status, want.src, want.dst, want.hdr, want.slot, want.last);
        $display("%0t: actual   st=%0d src=%h dst=%h hdr=%0d slot=%0d last=%b",
                 $time, got.status, got.src, got.dst, got.hdr, got.slot, got.last);
      end
    end
  endtask

  task automatic queue_request(input logic [1:0] kind, input logic [23:0] blk);
    pending_reqs.push_back({kind, blk});
  endtask

  // Register write; the private copy is updated as the write is driven.
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_LOG_START:  c_start   = val;
      CFG_LOG_SIZE:   c_size    = val[10:0];
      CFG_OP_RESERVE: c_reserve = val[4:0];
      default:        c_enabled = val[0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every request is taken and every due word has arrived.
  task automatic drain();
    while (pending_reqs.size() != 0 || holding || log_results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Half the time a block from a small pool, so that repeats get absorbed.
  function automatic logic [23:0] pick_block();
    if ($urandom_range(1) == 0) begin
      pick_block = hot_blocks[$urandom_range(HOT_COUNT - 1)];
    end else begin
      pick_block = 24'($urandom);
    end
  endfunction

  // Mostly well-formed transactions with random content, with some noise
  // words and the odd missing or stray end.
  task automatic run_random_phase(input int send_pct, input int stall_pct,
                                  input int txns, input int max_writes);
    int t;
    int k;
    int opens;
    int closes;
    int writes;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (k = 0; k < HOT_COUNT; k++) hot_blocks[k] = 24'($urandom);
    for (t = 0; t < txns; t++) begin
      opens  = $urandom_range(3, 1);
      writes = $urandom_range(max_writes, 0);
      case ($urandom_range(5))
        0:       closes = opens - 1;
        1:       closes = opens + 1;
        default: closes = opens;
      endcase
      repeat (opens) queue_request(REQ_BEGIN, 24'($urandom));
      repeat (writes) begin
        if ($urandom_range(7) == 0) begin
          queue_request(2'($urandom), 24'($urandom));
        end else begin
          queue_request(REQ_WRITE, pick_block());
        end
      end
      repeat (closes) queue_request(REQ_END, 24'($urandom));
    end
    drain();
  endtask

  // Request driver: a word stays offered, unchanged, until it is taken.
  always @(negedge clk) begin
    if (req_taken) begin
      req_taken = 1'b0;
      holding   = 1'b0;
    end
    if (!rst && !holding && pending_reqs.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      next_req     = pending_reqs.pop_front();
      req_type     <= next_req.kind;
      block_number <= next_req.blk;
      holding      = 1'b1;
    end
    req_valid <= holding;
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each taken request and checks each result word.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        play_request(req_type, block_number);
        req_taken = 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
        seen_word = {status, src_block, dst_block, header_count, slot, last};
        if (log_results_due.size() == 0) begin
          report_mismatch(1'b1, '0, seen_word);
        end else begin
          due_word = log_results_due.pop_front();
          if (seen_word.status !== due_word.status || seen_word.src !== due_word.src ||
              seen_word.dst !== due_word.dst || seen_word.hdr !== due_word.hdr ||
              seen_word.slot !== due_word.slot || seen_word.last !== due_word.last) begin
            report_mismatch(1'b0, due_word, seen_word);
          end
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int i;
    logic [23:0] blk;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Logging is off after reset, so requests are answered as disabled.
    queue_request(REQ_WRITE, 24'hFFFFFF);
    queue_request(REQ_UNKNOWN, 24'h000000);
    drain();

    // Log placed so that the slot addresses wrap past the top block number.
    write_reg(CFG_LOG_START, 24'hFFFFFE);
    write_reg(CFG_LOG_SIZE, 24'd1024);
    write_reg(CFG_OP_RESERVE, 24'd1);
    write_reg(CFG_LOG_ENABLED, 24'd1);

    // Unmatched end, write outside a transaction, unknown request type,
    // then a nested transaction with an absorbed repeat.
    queue_request(REQ_END, 24'h000000);
    queue_request(REQ_WRITE, 24'h000001);
    queue_request(REQ_UNKNOWN, 24'hFFFFFF);
    queue_request(REQ_BEGIN, 24'h000000);
    queue_request(REQ_BEGIN, 24'h000000);
    queue_request(REQ_WRITE, 24'h000000);
    queue_request(REQ_WRITE, 24'hFFFFFF);
    queue_request(REQ_WRITE, 24'h000000);
    queue_request(REQ_WRITE, 24'h5A5A5A);
    drain();

    // Disabling in mid-transaction leaves the state untouched.
    write_reg(CFG_LOG_ENABLED, 24'd0);
    queue_request(REQ_BEGIN, 24'h000000);
    queue_request(REQ_END, 24'h000000);
    drain();
    write_reg(CFG_LOG_ENABLED, 24'd1);

    // Inner end, last end with commit, then a last end on an empty table.
    queue_request(REQ_END, 24'h000000);
    queue_request(REQ_END, 24'h000000);
    queue_request(REQ_BEGIN, 24'h000000);
    queue_request(REQ_END, 24'h000000);
    drain();

    // Tiny logs: the size check wins even outside a transaction.
    write_reg(CFG_LOG_SIZE, 24'd0);
    queue_request(REQ_WRITE, 24'h123456);
    queue_request(REQ_BEGIN, 24'h000000);
    drain();
    write_reg(CFG_LOG_SIZE, 24'd1);
    queue_request(REQ_WRITE, 24'h123456);
    drain();
    write_reg(CFG_LOG_SIZE, 24'd2);
    queue_request(REQ_WRITE, 24'h123456);
    queue_request(REQ_WRITE, 24'h123456);
    queue_request(REQ_END, 24'h000000);
    drain();

    // Largest reserve: no operation can ever be granted.
    write_reg(CFG_OP_RESERVE, 24'd31);
    queue_request(REQ_BEGIN, 24'h000000);
    drain();

    // Random phases under varied settings and idling.
    write_reg(CFG_LOG_START, 24'h000000);
    write_reg(CFG_LOG_SIZE, 24'd31);
    write_reg(CFG_OP_RESERVE, 24'd10);
    run_random_phase(0, 0, 2, 10);

    write_reg(CFG_LOG_START, 24'($urandom));
    write_reg(CFG_LOG_SIZE, 24'd12);
    write_reg(CFG_OP_RESERVE, 24'd3);
    run_random_phase(56, 0, 2, 14);

    write_reg(CFG_LOG_START, 24'hFFFFFF);
    write_reg(CFG_LOG_SIZE, 24'd1024);
    write_reg(CFG_OP_RESERVE, 24'd5);
    run_random_phase(0, 56, 2, 10);

    write_reg(CFG_LOG_START, 24'($urandom));
    write_reg(CFG_LOG_SIZE, 24'd2047);
    write_reg(CFG_OP_RESERVE, 24'd2);
    run_random_phase(10, 10, 2, 10);

    // Close whatever the random phases left open, committing leftovers.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (m_open) queue_request(REQ_END, 24'($urandom));
    drain();

    // Full table under a long receiver hold-off: the sender keeps offering
    // words while the block backs up, then the longest commit plays out.
    write_reg(CFG_OP_RESERVE, 24'd1);
    hold_request = 1'b1;
    queue_request(REQ_BEGIN, 24'($urandom));
    for (i = 0; i <= LOG_ENTRIES; i++) begin
      blk      = 24'($urandom);
      blk[4:0] = 5'(i);
      queue_request(REQ_WRITE, blk);
    end
    queue_request(REQ_BEGIN, 24'($urandom));
    queue_request(REQ_END, 24'($urandom));
    drain();

    // No reserve: the open-operation count saturates and then must wait.
    write_reg(CFG_OP_RESERVE, 24'd0);
    write_reg(CFG_LOG_START, 24'hFFFFFF);
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    repeat (OPEN_MAX + 1) queue_request(REQ_BEGIN, 24'($urandom));
    queue_request(REQ_WRITE, 24'hFFFFFF);
    queue_request(REQ_UNKNOWN, 24'($urandom));
    repeat (OPEN_MAX + 1) queue_request(REQ_END, 24'($urandom));
    drain();

    if (mismatch_count == 0 && log_results_due.size() == 0) begin
      $display("redo_log_transaction_tracker test passed");
    end else begin
      $display("redo_log_transaction_tracker test failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("redo_log_transaction_tracker test failed");
    $finish;
  end

endmodule
